// ===== design/bglf_pkg.sv =====
`default_nettype none
package bglf_pkg;

  localparam int unsigned CntW = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [CntW-1:0] cnt_t;
  typedef logic [1:0] phase_t;
  typedef logic [1:0] led_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_LONG   = 2'd1,
    GEST_SHORT  = 2'd2,
    GEST_DOUBLE = 2'd3
  } gesture_t;

  localparam cfg_idx_t CFG_SHORT_INTERVAL = 2'd0;
  localparam cfg_idx_t CFG_LONG_INTERVAL  = 2'd1;
  localparam cfg_idx_t CFG_PRESS_WINDOW   = 2'd2;

  localparam phase_t PHASE_IDLE = 2'd0;
  localparam phase_t PHASE_HELD_AGAIN = 2'd3;
  localparam phase_t PHASE_RELEASED = 2'd2;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  localparam led_t LED_NONE  = 2'b00;
  localparam led_t LED_RED   = 2'b01;
  localparam led_t LED_GREEN = 2'b10;
  localparam led_t LED_BOTH  = 2'b11;

  localparam cnt_t SHORT_INTERVAL_RST = 16'd30;
  localparam cnt_t LONG_INTERVAL_RST  = 16'd90;
  localparam cnt_t PRESS_WINDOW_RST   = 16'd60;

  typedef struct packed {
    cnt_t short_interval;
    cnt_t long_interval;
    cnt_t press_window;
  } cfg_regs_t;

  typedef struct packed {
    led_t     leds;
    gesture_t gesture;
    phase_t   phase;
  } result_t;

endpackage
`default_nettype wire

// ===== design/bglf_in_if.sv =====
`default_nettype none
interface bglf_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic edge_rising;

  modport source (output valid, output cmd, output edge_rising, input ready);
  modport sink (input valid, input cmd, input edge_rising, output ready);
endinterface
`default_nettype wire

// ===== design/bglf_out_if.sv =====
`default_nettype none
interface bglf_out_if;
  logic       valid;
  logic       ready;
  logic       red_led;
  logic       green_led;
  logic [1:0] gesture;
  logic [1:0] tracker_phase;

  modport source (output valid, output red_led, output green_led, output gesture,
                  output tracker_phase, input ready);
  modport sink (input valid, input red_led, input green_led, input gesture,
                input tracker_phase, output ready);
endinterface
`default_nettype wire

// ===== design/bglf_cfg_if.sv =====
`default_nettype none
interface bglf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/bglf_cfg_regs.sv =====
`default_nettype none
module bglf_cfg_regs
  import bglf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_en,
  input  wire cfg_idx_t  wr_index,
  input  wire cnt_t      wr_data,
  output cfg_regs_t      cfg
);

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_SHORT_INTERVAL: cfg_nxt.short_interval = wr_data;
        CFG_LONG_INTERVAL:  cfg_nxt.long_interval  = wr_data;
        CFG_PRESS_WINDOW:   cfg_nxt.press_window   = wr_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_interval <= SHORT_INTERVAL_RST;
      cfg_r.long_interval  <= LONG_INTERVAL_RST;
      cfg_r.press_window   <= PRESS_WINDOW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== design/bglf_tracker.sv =====
`default_nettype none
module bglf_tracker
  import bglf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      fire,
  input  wire logic      cmd,
  input  wire logic      edge_rising,
  input  wire cfg_regs_t cfg,
  output result_t        res
);

  phase_t phase_r, phase_nxt;
  cnt_t   timeout_r, timeout_nxt;
  led_t   mask_r, mask_nxt;
  cnt_t   flash_left_r, flash_left_nxt;
  cnt_t   period_r, period_nxt;
  led_t   leds_r, leds_nxt;
  gesture_t gesture;
  cnt_t   flash_dec;
  cnt_t   timeout_dec;

  always_comb begin
    phase_nxt      = phase_r;
    timeout_nxt    = timeout_r;
    mask_nxt       = mask_r;
    flash_left_nxt = flash_left_r;
    period_nxt     = period_r;
    leds_nxt       = leds_r;
    gesture        = GEST_NONE;
    flash_dec      = flash_left_r - cnt_t'(1);
    timeout_dec    = timeout_r - cnt_t'(1);
    if (cmd == CMD_EDGE) begin
      // even phases want a press, odd phases a release
      if (edge_rising == phase_r[0]) begin
        if (phase_r == PHASE_HELD_AGAIN) begin
          mask_nxt       = LED_BOTH;
          period_nxt     = cfg.short_interval;
          flash_left_nxt = cfg.short_interval;
          leds_nxt       = (leds_r | LED_GREEN) & ~LED_RED;
          phase_nxt      = PHASE_IDLE;
          timeout_nxt    = '0;
          gesture        = GEST_DOUBLE;
        end else begin
          phase_nxt   = phase_r + phase_t'(1);
          timeout_nxt = cfg.press_window;
        end
      end
    end else begin
      flash_left_nxt = flash_dec;
      if (flash_dec == '0) begin
        leds_nxt       = leds_r ^ mask_r;
        flash_left_nxt = period_r;
      end
      if (timeout_r != '0) begin
        timeout_nxt = timeout_dec;
        if (timeout_dec == '0) begin
          if (phase_r[0]) begin
            mask_nxt       = LED_GREEN;
            period_nxt     = cfg.long_interval;
            flash_left_nxt = cfg.long_interval;
            leds_nxt       = LED_NONE;
            gesture        = GEST_LONG;
          end else if (phase_r == PHASE_RELEASED) begin
            mask_nxt       = LED_RED;
            period_nxt     = cfg.short_interval;
            flash_left_nxt = cfg.short_interval;
            leds_nxt       = leds_nxt & ~LED_GREEN;
            gesture        = GEST_SHORT;
          end
          phase_nxt = PHASE_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PHASE_IDLE;
      timeout_r    <= '0;
      mask_r       <= LED_GREEN;
      flash_left_r <= LONG_INTERVAL_RST;
      period_r     <= LONG_INTERVAL_RST;
      leds_r       <= LED_NONE;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      timeout_r    <= timeout_nxt;
      mask_r       <= mask_nxt;
      flash_left_r <= flash_left_nxt;
      period_r     <= period_nxt;
      leds_r       <= leds_nxt;
    end
  end

  assign res.leds    = leds_nxt;
  assign res.gesture = gesture;
  assign res.phase   = phase_nxt;

endmodule
`default_nettype wire

// ===== design/button_gesture_led_flasher_core.sv =====
`default_nettype none
// an input transaction is registered in the input register, then in the result register, which drives result valid
// throughput: one transaction per cycle while the result is taken, input register feeds result register
// a stalled result register holds while an empty input register takes the next item
// reset (rst_n low, synchronous): pipeline empty, tracker idle, green flash mask,
// flash countdown 90, leds off, interval registers back to 30, 90 and 60
module button_gesture_led_flasher_core
  import bglf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  bglf_in_if.sink   in_if,
  bglf_out_if.source out_if,
  bglf_cfg_if.sink  cfg_if
);

  logic      s1_valid_r;
  logic      s1_cmd_r;
  logic      s1_rise_r;
  logic      out_valid_r;
  result_t   out_res_r;
  logic      advance;
  cfg_regs_t cfg;
  result_t   res;

  assign advance      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || advance;
  assign cfg_if.ready = 1'b1;

  bglf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_if.valid),
    .wr_index (cfg_if.index),
    .wr_data  (cfg_if.data),
    .cfg      (cfg)
  );

  bglf_tracker u_trk (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (advance),
    .cmd         (s1_cmd_r),
    .edge_rising (s1_rise_r),
    .cfg         (cfg),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_if.ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_cmd_r  <= in_if.cmd;
      s1_rise_r <= in_if.edge_rising;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.red_led       = out_res_r.leds[0];
  assign out_if.green_led     = out_res_r.leds[1];
  assign out_if.gesture       = out_res_r.gesture;
  assign out_if.tracker_phase = out_res_r.phase;

endmodule
`default_nettype wire

// ===== design/bglf_checker.sv =====
`default_nettype none
module bglf_checker
  import bglf_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       red_led,
  input wire logic       green_led,
  input wire logic [1:0] gesture,
  input wire logic [1:0] tracker_phase
);

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(gesture) && $stable(tracker_phase))
    else $error("stalled result dropped or changed");

  // any finished gesture leaves the tracker idle
  a_gest_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && gesture != GEST_NONE |-> tracker_phase == PHASE_IDLE)
    else $error("gesture without idle tracker");

  a_double_leds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && gesture == GEST_DOUBLE |-> green_led && !red_led)
    else $error("double press led levels wrong");

  a_long_leds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (gesture == GEST_LONG || gesture == GEST_SHORT) |-> !green_led)
    else $error("green lit after long or single press");

endmodule

bind button_gesture_led_flasher_core bglf_checker u_bglf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .red_led       (out_if.red_led),
  .green_led     (out_if.green_led),
  .gesture       (out_if.gesture),
  .tracker_phase (out_if.tracker_phase)
);
`default_nettype wire
